### rtl/prescaled_dual_8bit_reload_timer_defines.svh
// Assertion macros for the prescaled dual reload timer checker.
`ifndef PRESCALED_DUAL_8BIT_RELOAD_TIMER_DEFINES_SVH
`define PRESCALED_DUAL_8BIT_RELOAD_TIMER_DEFINES_SVH

// same-cycle implication
`define PDRT_ASSERT_NOW(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("pdrt assertion failed");

// next-cycle implication
`define PDRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("pdrt assertion failed");

`endif

### rtl/pdrt_pkg.sv
// Shared types and constants of the prescaled dual reload timer.
package pdrt_pkg;

   localparam int HALF_WIDTH = 8;
   localparam int CYCLES_W  = 4;
   localparam int PERIOD_W  = 9;
   localparam int SUM_W     = 10;
   localparam int DIV_STEPS = 10;
   localparam int STEP_W    = 4;
   localparam int OUT_W     = HALF_WIDTH;
   localparam int RELOAD_W  = HALF_WIDTH;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_RUN_LOW     = 3'd0;
   localparam logic [2:0] REG_RUN_HIGH    = 3'd1;
   localparam logic [2:0] REG_LONG_MODE   = 3'd2;
   localparam logic [2:0] REG_IRQ_EN_LOW  = 3'd3;
   localparam logic [2:0] REG_IRQ_EN_HIGH = 3'd4;
   localparam logic [2:0] REG_RELOAD_LOW  = 3'd5;
   localparam logic [2:0] REG_RELOAD_HIGH = 3'd6;
   localparam logic [2:0] REG_PERIOD      = 3'd7;

   typedef struct packed {
      logic                done;
      logic [SUM_W-1:0]    quotient;
      logic [PERIOD_W-1:0] remainder;
   } div_status_type;

endpackage

### rtl/pdrt_divider.sv
// Restoring divider: one shared subtract/compare step per cycle.
module pdrt_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pdrt_pkg::SUM_W-1:0]    dividend,
   input  logic [pdrt_pkg::PERIOD_W-1:0] divisor,
   output pdrt_pkg::div_status_type      status
);

   logic                          active_ff, active_in;
   logic                          done_ff, done_in;
   logic [pdrt_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [pdrt_pkg::SUM_W-1:0]    dq_ff, dq_in;
   logic [pdrt_pkg::PERIOD_W-1:0] rem_ff, rem_in;
   logic [pdrt_pkg::PERIOD_W-1:0] divisor_ff, divisor_in;
   logic [pdrt_pkg::SUM_W-1:0]    trial;
   logic [pdrt_pkg::SUM_W-1:0]    diff;
   logic                          ge;

   assign trial = {rem_ff, dq_ff[pdrt_pkg::SUM_W-1]};
   assign ge    = trial >= {1'b0, divisor_ff};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      active_in  = active_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         active_in  = 1'b1;
         step_in    = '0;
         dq_in      = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (active_ff) begin
         rem_in  = ge ? diff[pdrt_pkg::PERIOD_W-1:0] : trial[pdrt_pkg::PERIOD_W-1:0];
         dq_in   = {dq_ff[pdrt_pkg::SUM_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == pdrt_pkg::STEP_W'(pdrt_pkg::DIV_STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      step_ff    <= step_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status = {done_ff, dq_ff, rem_ff};

endmodule

### rtl/prescaled_dual_8bit_reload_timer.sv
// Prescaled dual reload timer: top level with sequencer, counters and CSRs.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_cycles, req_clear_flags
//  rsp     | out       | rsp_valid / rsp_stall | counts, flags, irqs
//  csr     | in/out    | psel / penable        | paddr, pwdata, prdata
//
// While a half runs, a transaction passes through the ten subtract steps of the
// prescaler divider; with both halves halted it goes from idle straight to push.
// Reset is synchronous and clears the control state, counters, flags and CSRs; no clearing pass is needed.
// A finished result waits in the output register; a stalled rsp side holds
// the sequencer in its last state until the register frees up.
module prescaled_dual_8bit_reload_timer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pdrt_pkg::CYCLES_W-1:0]   req_cycles,
   input  logic [1:0]                      req_clear_flags,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pdrt_pkg::OUT_W-1:0]      rsp_count_low_out,
   output logic [pdrt_pkg::OUT_W-1:0]      rsp_count_high_out,
   output logic                            rsp_flag_low_out,
   output logic                            rsp_flag_high_out,
   output logic                            rsp_irq_low,
   output logic                            rsp_irq_high,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pdrt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pdrt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pdrt_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int HW = pdrt_pkg::HALF_WIDTH;
   localparam int SW = HW + 3;
   localparam int JW = 2 * HW + 1;
   localparam logic [SW-1:0] HalfMod  = {2'b00, 1'b1, {HW{1'b0}}};
   localparam logic [JW-1:0] JointMod = {1'b1, {(2 * HW){1'b0}}};

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_ADV  = 2'd2;
   localparam logic [1:0] ST_PUSH = 2'd3;

   logic [1:0] state_ff, state_in;

   logic                            run_low_ff, run_high_ff, long_mode_ff;
   logic                            irq_en_low_ff, irq_en_high_ff;
   logic [pdrt_pkg::RELOAD_W-1:0]   reload_low_ff, reload_high_ff;
   logic [pdrt_pkg::PERIOD_W-1:0]   period_ff;

   logic [pdrt_pkg::PERIOD_W-1:0]   accum_ff, accum_in;
   logic [HW-1:0]                   count_low_ff, count_low_in;
   logic [HW-1:0]                   count_high_ff, count_high_in;
   logic                            flag_low_ff, flag_low_in;
   logic                            flag_high_ff, flag_high_in;
   logic [pdrt_pkg::SUM_W-1:0]      ticks_ff, ticks_in;
   logic                            il_pend_ff, il_pend_in;
   logic                            ih_pend_ff, ih_pend_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pdrt_pkg::OUT_W-1:0]      out_count_low_ff, out_count_low_in;
   logic [pdrt_pkg::OUT_W-1:0]      out_count_high_ff, out_count_high_in;
   logic                            out_flag_low_ff, out_flag_low_in;
   logic                            out_flag_high_ff, out_flag_high_in;
   logic                            out_irq_low_ff, out_irq_low_in;
   logic                            out_irq_high_ff, out_irq_high_in;

   logic                            div_start;
   logic [pdrt_pkg::SUM_W-1:0]      div_dividend;
   logic [pdrt_pkg::PERIOD_W-1:0]   div_divisor;
   pdrt_pkg::div_status_type        div_status;

   logic                            csr_write;
   logic [2:0]                      csr_index;

   logic [SW-1:0] lo_sum, lo_wrap, hi_sum, hi_wrap;
   logic          lo_ovf, hi_ovf, jn_ovf, joined;
   logic [HW-1:0] lo_next, hi_next;
   logic [JW-1:0] jn_sum, jn_wrap;
   logic [2*HW-1:0] jn_next, jn_reload;

   // configuration registers
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[4:2];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_low_ff     <= 1'b0;
         run_high_ff    <= 1'b0;
         long_mode_ff   <= 1'b0;
         irq_en_low_ff  <= 1'b0;
         irq_en_high_ff <= 1'b0;
         reload_low_ff  <= '0;
         reload_high_ff <= '0;
         period_ff      <= pdrt_pkg::PERIOD_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            pdrt_pkg::REG_RUN_LOW:     run_low_ff     <= pwdata[0];
            pdrt_pkg::REG_RUN_HIGH:    run_high_ff    <= pwdata[0];
            pdrt_pkg::REG_LONG_MODE:   long_mode_ff   <= pwdata[0];
            pdrt_pkg::REG_IRQ_EN_LOW:  irq_en_low_ff  <= pwdata[0];
            pdrt_pkg::REG_IRQ_EN_HIGH: irq_en_high_ff <= pwdata[0];
            pdrt_pkg::REG_RELOAD_LOW:  reload_low_ff  <= pwdata[pdrt_pkg::RELOAD_W-1:0];
            pdrt_pkg::REG_RELOAD_HIGH: reload_high_ff <= pwdata[pdrt_pkg::RELOAD_W-1:0];
            pdrt_pkg::REG_PERIOD:      period_ff      <= pwdata[pdrt_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         pdrt_pkg::REG_RUN_LOW:     prdata = pdrt_pkg::CSR_DATA_W'(run_low_ff);
         pdrt_pkg::REG_RUN_HIGH:    prdata = pdrt_pkg::CSR_DATA_W'(run_high_ff);
         pdrt_pkg::REG_LONG_MODE:   prdata = pdrt_pkg::CSR_DATA_W'(long_mode_ff);
         pdrt_pkg::REG_IRQ_EN_LOW:  prdata = pdrt_pkg::CSR_DATA_W'(irq_en_low_ff);
         pdrt_pkg::REG_IRQ_EN_HIGH: prdata = pdrt_pkg::CSR_DATA_W'(irq_en_high_ff);
         pdrt_pkg::REG_RELOAD_LOW:  prdata = pdrt_pkg::CSR_DATA_W'(reload_low_ff);
         pdrt_pkg::REG_RELOAD_HIGH: prdata = pdrt_pkg::CSR_DATA_W'(reload_high_ff);
         pdrt_pkg::REG_PERIOD:      prdata = pdrt_pkg::CSR_DATA_W'(period_ff);
         default:                   prdata = '0;
      endcase
   end

   // prescaler divider
   assign div_dividend = pdrt_pkg::SUM_W'(accum_ff) + pdrt_pkg::SUM_W'(req_cycles);
   assign div_divisor  = (period_ff == '0) ? pdrt_pkg::PERIOD_W'(1) : period_ff;

   pdrt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status)
   );

   // counter advance with reload of the excess
   assign joined = long_mode_ff & run_low_ff & run_high_ff;

   assign lo_sum  = SW'(count_low_ff) + SW'(ticks_ff);
   assign lo_ovf  = lo_sum >= HalfMod;
   assign lo_wrap = lo_sum - HalfMod + SW'(reload_low_ff);
   assign lo_next = !lo_ovf ? lo_sum[HW-1:0] :
                    (lo_wrap >= HalfMod) ? HW'(reload_low_ff) : lo_wrap[HW-1:0];

   assign hi_sum  = SW'(count_high_ff) + SW'(ticks_ff);
   assign hi_ovf  = hi_sum >= HalfMod;
   assign hi_wrap = hi_sum - HalfMod + SW'(reload_high_ff);
   assign hi_next = !hi_ovf ? hi_sum[HW-1:0] :
                    (hi_wrap >= HalfMod) ? HW'(reload_high_ff) : hi_wrap[HW-1:0];

   assign jn_reload = {HW'(reload_high_ff), HW'(reload_low_ff)};
   assign jn_sum    = JW'({count_high_ff, count_low_ff}) + JW'(ticks_ff);
   assign jn_ovf    = jn_sum[JW-1];
   assign jn_wrap   = jn_sum - JointMod + JW'(jn_reload);
   assign jn_next   = !jn_ovf ? jn_sum[2*HW-1:0] :
                      jn_wrap[JW-1] ? jn_reload : jn_wrap[2*HW-1:0];

   // sequencer
   always_comb begin
      state_in          = state_ff;
      accum_in          = accum_ff;
      count_low_in      = count_low_ff;
      count_high_in     = count_high_ff;
      flag_low_in       = flag_low_ff;
      flag_high_in      = flag_high_ff;
      ticks_in          = ticks_ff;
      il_pend_in        = il_pend_ff;
      ih_pend_in        = ih_pend_ff;
      rsp_valid_in      = rsp_valid_ff & rsp_stall;
      out_count_low_in  = out_count_low_ff;
      out_count_high_in = out_count_high_ff;
      out_flag_low_in   = out_flag_low_ff;
      out_flag_high_in  = out_flag_high_ff;
      out_irq_low_in    = out_irq_low_ff;
      out_irq_high_in   = out_irq_high_ff;
      div_start         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               flag_low_in  = flag_low_ff & ~req_clear_flags[0];
               flag_high_in = flag_high_ff & ~req_clear_flags[1];
               il_pend_in   = 1'b0;
               ih_pend_in   = 1'b0;
               if (run_low_ff | run_high_ff) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in  = ST_PUSH;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               ticks_in = div_status.quotient;
               accum_in = div_status.remainder;
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            if (joined) begin
               count_low_in  = jn_next[HW-1:0];
               count_high_in = jn_next[2*HW-1:HW];
               if (jn_ovf) begin
                  flag_low_in  = 1'b1;
                  flag_high_in = 1'b1;
                  ih_pend_in   = irq_en_high_ff;
               end
            end else begin
               if (run_low_ff) begin
                  count_low_in = lo_next;
                  if (lo_ovf) begin
                     flag_low_in = 1'b1;
                     il_pend_in  = irq_en_low_ff;
                  end
               end
               if (run_high_ff) begin
                  count_high_in = hi_next;
                  if (hi_ovf) begin
                     flag_high_in = 1'b1;
                     ih_pend_in   = irq_en_high_ff;
                  end
               end
            end
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               out_count_low_in  = count_low_ff[pdrt_pkg::OUT_W-1:0];
               out_count_high_in = count_high_ff[pdrt_pkg::OUT_W-1:0];
               out_flag_low_in   = flag_low_ff;
               out_flag_high_in  = flag_high_ff;
               out_irq_low_in    = il_pend_ff;
               out_irq_high_in   = ih_pend_ff;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         accum_ff      <= '0;
         count_low_ff  <= '0;
         count_high_ff <= '0;
         flag_low_ff   <= 1'b0;
         flag_high_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         accum_ff      <= accum_in;
         count_low_ff  <= count_low_in;
         count_high_ff <= count_high_in;
         flag_low_ff   <= flag_low_in;
         flag_high_ff  <= flag_high_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ticks_ff          <= ticks_in;
      il_pend_ff        <= il_pend_in;
      ih_pend_ff        <= ih_pend_in;
      out_count_low_ff  <= out_count_low_in;
      out_count_high_ff <= out_count_high_in;
      out_flag_low_ff   <= out_flag_low_in;
      out_flag_high_ff  <= out_flag_high_in;
      out_irq_low_ff    <= out_irq_low_in;
      out_irq_high_ff   <= out_irq_high_in;
   end

   assign req_stall          = reset | (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_count_low_out  = out_count_low_ff;
   assign rsp_count_high_out = out_count_high_ff;
   assign rsp_flag_low_out   = out_flag_low_ff;
   assign rsp_flag_high_out  = out_flag_high_ff;
   assign rsp_irq_low        = out_irq_low_ff;
   assign rsp_irq_high       = out_irq_high_ff;

endmodule

### rtl/pdrt_checker.sv
// Port-level checker for the prescaled dual reload timer, with its bind.
`include "prescaled_dual_8bit_reload_timer_defines.svh"

module pdrt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [pdrt_pkg::OUT_W-1:0]      rsp_count_low_out,
   input logic [pdrt_pkg::OUT_W-1:0]      rsp_count_high_out,
   input logic                            rsp_flag_low_out,
   input logic                            rsp_flag_high_out,
   input logic                            rsp_irq_low,
   input logic                            rsp_irq_high
);

   logic                           rsp_wait;
   logic [2*pdrt_pkg::OUT_W-1:0]   rsp_counts;

   assign rsp_wait   = rsp_valid && rsp_stall;
   assign rsp_counts = {rsp_count_high_out, rsp_count_low_out};

   // one transaction at a time
   `PDRT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // an interrupt always comes with its sticky flag
   `PDRT_ASSERT_NOW(a_irq_low_flag, clock, reset, rsp_valid && rsp_irq_low, rsp_flag_low_out)

   `PDRT_ASSERT_NOW(a_irq_high_flag, clock, reset, rsp_valid && rsp_irq_high, rsp_flag_high_out)

   `PDRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_counts))

endmodule

bind prescaled_dual_8bit_reload_timer pdrt_checker u_pdrt_checker (.*);

### tb/pdrt_timer_checker.sv
// Checker for the prescaled dual reload timer: tracks CSR writes, predicts and compares.
module pdrt_timer_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [pdrt_pkg::CYCLES_W-1:0]   req_cycles,
   input  logic [1:0]                      req_clear_flags,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [pdrt_pkg::OUT_W-1:0]      rsp_count_low_out,
   input  logic [pdrt_pkg::OUT_W-1:0]      rsp_count_high_out,
   input  logic                            rsp_flag_low_out,
   input  logic                            rsp_flag_high_out,
   input  logic                            rsp_irq_low,
   input  logic                            rsp_irq_high,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [pdrt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pdrt_pkg::CSR_DATA_W-1:0] pwdata,
   output int                              readouts_outstanding,
   output int                              mismatch_count
);

   localparam int unsigned HALF_MOD = 1 << pdrt_pkg::HALF_WIDTH;
   localparam int unsigned FULL_MOD = HALF_MOD * HALF_MOD;

   typedef struct packed {
      logic [pdrt_pkg::OUT_W-1:0] count_low;
      logic [pdrt_pkg::OUT_W-1:0] count_high;
      logic                       flag_low;
      logic                       flag_high;
      logic                       irq_low;
      logic                       irq_high;
   } timer_readout_type;

   logic                          run_low, run_high, long_mode, irq_en_low, irq_en_high;
   logic [pdrt_pkg::RELOAD_W-1:0] reload_low, reload_high;
   logic [pdrt_pkg::PERIOD_W-1:0] period;
   logic [pdrt_pkg::PERIOD_W-1:0] accum;
   logic [pdrt_pkg::OUT_W-1:0]    count_low, count_high;
   logic                          flag_low, flag_high;

   timer_readout_type pending_readouts[$];

   // reload on overflow; plain reload when reload plus excess overflows again
   function automatic int unsigned wrap_count(int unsigned value, int unsigned modulus,
                                              int unsigned reload, output logic wrapped);
      int unsigned v;
      v = value;
      wrapped = 1'b0;
      if (v >= modulus) begin
         wrapped = 1'b1;
         v = v - modulus + reload;
         if (v >= modulus) v = reload;
      end
      return v;
   endfunction

   function automatic timer_readout_type timer_step(logic [pdrt_pkg::CYCLES_W-1:0] cyc,
                                                    logic [1:0] clr);
      timer_readout_type r;
      int unsigned       per, sum, ticks, joined, half;
      logic              wrapped;
      r = '0;
      if (clr[0]) flag_low = 1'b0;
      if (clr[1]) flag_high = 1'b0;
      if (run_low || run_high) begin
         per = (period == '0) ? 32'd1 : 32'(period);
         sum = 32'(accum) + 32'(cyc);
         ticks = sum / per;
         accum = pdrt_pkg::PERIOD_W'(sum % per);
         if (ticks != 0) begin
            if (long_mode && run_low && run_high) begin
               joined = wrap_count(32'({count_high, count_low}) + ticks, FULL_MOD,
                                   32'({reload_high, reload_low}), wrapped);
               count_low = pdrt_pkg::OUT_W'(joined);
               count_high = pdrt_pkg::OUT_W'(joined >> pdrt_pkg::OUT_W);
               if (wrapped) begin
                  flag_low = 1'b1;
                  flag_high = 1'b1;
                  r.irq_high = irq_en_high;
               end
            end else begin
               if (run_low) begin
                  half = wrap_count(32'(count_low) + ticks, HALF_MOD, 32'(reload_low),
                                    wrapped);
                  count_low = pdrt_pkg::OUT_W'(half);
                  if (wrapped) begin
                     flag_low = 1'b1;
                     r.irq_low = irq_en_low;
                  end
               end
               if (run_high) begin
                  half = wrap_count(32'(count_high) + ticks, HALF_MOD, 32'(reload_high),
                                    wrapped);
                  count_high = pdrt_pkg::OUT_W'(half);
                  if (wrapped) begin
                     flag_high = 1'b1;
                     r.irq_high = irq_en_high;
                  end
               end
            end
         end
      end
      r.count_low = count_low;
      r.count_high = count_high;
      r.flag_low = flag_low;
      r.flag_high = flag_high;
      return r;
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      timer_readout_type want;
      if (reset) begin
         run_low = 1'b0;
         run_high = 1'b0;
         long_mode = 1'b0;
         irq_en_low = 1'b0;
         irq_en_high = 1'b0;
         reload_low = '0;
         reload_high = '0;
         period = pdrt_pkg::PERIOD_W'(1);
         accum = '0;
         count_low = '0;
         count_high = '0;
         flag_low = 1'b0;
         flag_high = 1'b0;
         pending_readouts.delete();
         mismatch_count = 0;
         readouts_outstanding <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[pdrt_pkg::CSR_ADDR_W-1:2])
               pdrt_pkg::REG_RUN_LOW:     run_low = pwdata[0];
               pdrt_pkg::REG_RUN_HIGH:    run_high = pwdata[0];
               pdrt_pkg::REG_LONG_MODE:   long_mode = pwdata[0];
               pdrt_pkg::REG_IRQ_EN_LOW:  irq_en_low = pwdata[0];
               pdrt_pkg::REG_IRQ_EN_HIGH: irq_en_high = pwdata[0];
               pdrt_pkg::REG_RELOAD_LOW:  reload_low = pwdata[pdrt_pkg::RELOAD_W-1:0];
               pdrt_pkg::REG_RELOAD_HIGH: reload_high = pwdata[pdrt_pkg::RELOAD_W-1:0];
               pdrt_pkg::REG_PERIOD:      period = pwdata[pdrt_pkg::PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pending_readouts.push_back(timer_step(req_cycles, req_clear_flags));
         if (rsp_valid && !rsp_stall) begin
            if (pending_readouts.size() == 0) begin
               $display("%0t: unexpected transaction: expected none, actual %0d %0d %b %b %b %b",
                        $time, rsp_count_low_out, rsp_count_high_out, rsp_flag_low_out,
                        rsp_flag_high_out, rsp_irq_low, rsp_irq_high);
               mismatch_count++;
            end else begin
               want = pending_readouts.pop_front();
               check_field("count_low_out", 32'(want.count_low), 32'(rsp_count_low_out));
               check_field("count_high_out", 32'(want.count_high), 32'(rsp_count_high_out));
               check_field("flag_low_out", 32'(want.flag_low), 32'(rsp_flag_low_out));
               check_field("flag_high_out", 32'(want.flag_high), 32'(rsp_flag_high_out));
               check_field("irq_low", 32'(want.irq_low), 32'(rsp_irq_low));
               check_field("irq_high", 32'(want.irq_high), 32'(rsp_irq_high));
            end
         end
         readouts_outstanding <= pending_readouts.size();
      end
   end

endmodule

### tb/prescaled_dual_8bit_reload_timer_tb.sv
// Testbench top for the prescaled dual reload timer: clock, reset, CSR setup, stimulus, verdict.
module prescaled_dual_8bit_reload_timer_tb;

   localparam int NUM_PHASES       = 17;
   localparam int ITEMS_PER_PHASE  = 50;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int HOLD_PHASE       = 3;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [pdrt_pkg::CYCLES_W-1:0]   req_cycles;
   logic [1:0]                      req_clear_flags;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [pdrt_pkg::OUT_W-1:0]      rsp_count_low_out;
   logic [pdrt_pkg::OUT_W-1:0]      rsp_count_high_out;
   logic                            rsp_flag_low_out;
   logic                            rsp_flag_high_out;
   logic                            rsp_irq_low;
   logic                            rsp_irq_high;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [pdrt_pkg::CSR_ADDR_W-1:0] paddr;
   logic [pdrt_pkg::CSR_DATA_W-1:0] pwdata;
   logic [pdrt_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   int readouts_outstanding;
   int mismatch_count;
   bit idle_on;
   bit hold_off_pending;

   prescaled_dual_8bit_reload_timer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cycles         (req_cycles),
      .req_clear_flags    (req_clear_flags),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_count_low_out  (rsp_count_low_out),
      .rsp_count_high_out (rsp_count_high_out),
      .rsp_flag_low_out   (rsp_flag_low_out),
      .rsp_flag_high_out  (rsp_flag_high_out),
      .rsp_irq_low        (rsp_irq_low),
      .rsp_irq_high       (rsp_irq_high),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   pdrt_timer_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cycles           (req_cycles),
      .req_clear_flags      (req_clear_flags),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_count_low_out    (rsp_count_low_out),
      .rsp_count_high_out   (rsp_count_high_out),
      .rsp_flag_low_out     (rsp_flag_low_out),
      .rsp_flag_high_out    (rsp_flag_high_out),
      .rsp_irq_low          (rsp_irq_low),
      .rsp_irq_high         (rsp_irq_high),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .pready               (pready),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .readouts_outstanding (readouts_outstanding),
      .mismatch_count       (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: short stall bursts, plus one long hold-off to back up the block
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_txn(input logic [pdrt_pkg::CYCLES_W-1:0] cyc, input logic [1:0] clr);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cycles <= cyc;
      req_clear_flags <= clr;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_readouts();
      req_valid <= 1'b0;
      do @(posedge clock); while (readouts_outstanding != 0);
   endtask

   // setup and access cycles; psel stays up between back-to-back writes
   task automatic write_reg(input logic [2:0] idx,
                            input logic [pdrt_pkg::CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic apply_setup(input logic rl, input logic rh, input logic lm,
                              input logic iel, input logic ieh,
                              input logic [pdrt_pkg::RELOAD_W-1:0] rel_lo,
                              input logic [pdrt_pkg::RELOAD_W-1:0] rel_hi,
                              input logic [pdrt_pkg::PERIOD_W-1:0] per);
      write_reg(pdrt_pkg::REG_RUN_LOW, pdrt_pkg::CSR_DATA_W'(rl));
      write_reg(pdrt_pkg::REG_RUN_HIGH, pdrt_pkg::CSR_DATA_W'(rh));
      write_reg(pdrt_pkg::REG_LONG_MODE, pdrt_pkg::CSR_DATA_W'(lm));
      write_reg(pdrt_pkg::REG_IRQ_EN_LOW, pdrt_pkg::CSR_DATA_W'(iel));
      write_reg(pdrt_pkg::REG_IRQ_EN_HIGH, pdrt_pkg::CSR_DATA_W'(ieh));
      write_reg(pdrt_pkg::REG_RELOAD_LOW, pdrt_pkg::CSR_DATA_W'(rel_lo));
      write_reg(pdrt_pkg::REG_RELOAD_HIGH, pdrt_pkg::CSR_DATA_W'(rel_hi));
      write_reg(pdrt_pkg::REG_PERIOD, pdrt_pkg::CSR_DATA_W'(per));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [pdrt_pkg::RELOAD_W-1:0] pick_reload(input bit near_top);
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return near_top ? pdrt_pkg::RELOAD_W'($urandom_range(8'hF0, 8'hFF))
                                  : pdrt_pkg::RELOAD_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [pdrt_pkg::PERIOD_W-1:0] pick_period();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return pdrt_pkg::PERIOD_W'(256);
         2:       return pdrt_pkg::PERIOD_W'($urandom_range(1, 256));
         default: return pdrt_pkg::PERIOD_W'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      logic                          rl, rh, lm, iel, ieh;
      logic [pdrt_pkg::RELOAD_W-1:0] rel_lo, rel_hi;
      logic [pdrt_pkg::PERIOD_W-1:0] per;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cycles = '0;
      req_clear_flags = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      idle_on = 1'b1;
      hold_off_pending = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // both halves halted after reset: state holds
      send_txn(4'd15, 2'd3);
      send_txn(4'd0, 2'd0);
      drain_readouts();

      // zero period counts as one
      apply_setup(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF, 8'h00, 9'd0);
      for (int i = 0; i < 4; i++) send_txn(4'd15, 2'(i));
      drain_readouts();

      // widest period: cycles pile up in the prescaler without a tick
      apply_setup(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF, 8'h00, 9'd256);
      send_txn(4'd0, 2'd0);
      for (int i = 0; i < 13; i++) send_txn(4'd15, 2'd0);
      drain_readouts();

      // period dropped to one: a burst of ticks, low half overflows twice over
      apply_setup(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF, 8'hF1, 9'd1);
      send_txn(4'd15, 2'd0);
      drain_readouts();

      // joined 16-bit counter wraps: both flags, only the high interrupt
      apply_setup(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hF1, 9'd1);
      send_txn(4'd1, 2'd3);
      send_txn(4'd0, 2'd3);
      send_txn(4'd15, 2'd1);
      drain_readouts();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 0) begin
            rl = 1'b1; rh = 1'b1; lm = 1'b0; iel = 1'b1; ieh = 1'b1;
            rel_lo = '1; rel_hi = '1; per = pdrt_pkg::PERIOD_W'(256);
         end else if (p == 1) begin
            rl = 1'b1; rh = 1'b1; lm = 1'b0; iel = 1'b0; ieh = 1'b0;
            rel_lo = '0; rel_hi = '0; per = pdrt_pkg::PERIOD_W'(1);
         end else begin
            rl = ($urandom_range(0, 3) != 0);
            rh = ($urandom_range(0, 3) != 0);
            lm = 1'($urandom_range(0, 1));
            iel = 1'($urandom_range(0, 1));
            ieh = 1'($urandom_range(0, 1));
            rel_lo = pick_reload(1'b0);
            rel_hi = pick_reload(lm);
            per = pick_period();
         end
         apply_setup(rl, rh, lm, iel, ieh, rel_lo, rel_hi, per);
         idle_on = (p < NUM_PHASES - 2) ? ($urandom_range(0, 3) != 0) : 1'b0;
         if (p == HOLD_PHASE) hold_off_pending = 1'b1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            send_txn(pdrt_pkg::CYCLES_W'($urandom_range(0, 15)),
                     $urandom_range(0, 1) ? 2'd0 : 2'($urandom_range(0, 3)));
         drain_readouts();
      end

      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
